/* sv/rgbb_pkg.sv */
// Shared types and constants for the RGB 3x3 box blur.
package rgbb_pkg;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int COL_W     = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IMGW_W    = 13;
	localparam int SUM_W     = 12;
	localparam int RECIP_W   = 13;
	localparam int RECIP_SH  = 16;
	localparam int TAPS      = 9;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// ceil(2^16 / 9); exact floor(x / 9) for x below 2300
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
	localparam logic [SUM_W-1:0]   ROUND_4 = 12'd4;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

endpackage

/* sv/rgbb_line_store.sv */
// One row of RGB pixels: single write port, registered read port.
module rgbb_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output rgbb_pkg::rgb_t  rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rgbb_pkg::rgb_t  wr_data
);
	import rgbb_pkg::*;

	rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/rgbb_lane.sv */
// One color channel: 3x3 sum with rounding bias, then divide by nine.
module rgbb_lane (
	input  logic                         clk,
	input  logic                         en_s2,
	input  logic                         en_s3,
	input  rgbb_pkg::taps_t              taps,
	output logic [rgbb_pkg::PIX_W-1:0]   mean_s3
);
	import rgbb_pkg::*;

	logic [SUM_W-1:0]           col0, col1, col2;
	logic [SUM_W-1:0]           sum_s2;
	logic [SUM_W+RECIP_W-1:0]   prod;

	always_comb begin
		col0 = SUM_W'(taps[0]) + SUM_W'(taps[1]) + SUM_W'(taps[2]);
		col1 = SUM_W'(taps[3]) + SUM_W'(taps[4]) + SUM_W'(taps[5]);
		col2 = SUM_W'(taps[6]) + SUM_W'(taps[7]) + SUM_W'(taps[8]);
	end

	assign prod = (SUM_W+RECIP_W)'(sum_s2) * (SUM_W+RECIP_W)'(RECIP_9);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2 <= col0 + col1 + col2 + ROUND_4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mean_s3 <= prod[RECIP_SH +: PIX_W];
		end
	end

endmodule

/* sv/rgb_box_blur_3x3.sv */
// Pixels pass the input, sum, divide and output registers; out_valid rises with the result.
// Throughput: one pixel per clock unless stalled; line stores read at accept, write from s1.
// Interior pixels give one result, border pixels none.
// Reset clears counters, pipeline valids and sets width 640 (at most MAX_WIDTH), height 480.
// Line stores are not cleared; a width or height register write restarts the image.
module rgb_box_blur_3x3 #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rgbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgbb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rgbb_pkg::PIX_W-1:0]        red_in,
	input  logic [rgbb_pkg::PIX_W-1:0]        green_in,
	input  logic [rgbb_pkg::PIX_W-1:0]        blue_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rgbb_pkg::PIX_W-1:0]        red_out,
	output logic [rgbb_pkg::PIX_W-1:0]        green_out,
	output logic [rgbb_pkg::PIX_W-1:0]        blue_out,
	output logic [rgbb_pkg::ROW_W-1:0]        out_row,
	output logic [rgbb_pkg::COL_W-1:0]        out_col,
	output logic                              last_result
);
	import rgbb_pkg::*;

	localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam logic [AW-1:0]    WMAX_RST = AW'(W_RST - 1);
	localparam logic [ROW_W-1:0] HMAX_RST = ROW_W'(HEIGHT_RESET - 1);

	// configuration and position counters
	logic [AW-1:0]    wmax_q, col_q;
	logic [ROW_W-1:0] hmax_q, row_q;
	logic [31:0]      w_req, w_sel;
	logic             accept;

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic en_1, en_2, en_3, en_out;

	// stage 1
	rgb_t             pix_s1, up_rd, mid_rd;
	logic [AW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             emit_s1, last_s1, leave_s1;

	// window: two previous columns, top to bottom
	rgb_t win0_q [3];
	rgb_t win1_q [3];
	rgb_t newcol [3];

	// result metadata
	logic [ROW_W-1:0] orow_s2, orow_s3;
	logic [COL_W-1:0] ocol_s2, ocol_s3;
	logic             last_s2, last_s3;

	taps_t            taps_r, taps_g, taps_b;
	logic [PIX_W-1:0] mean_r_s3, mean_g_s3, mean_b_s3;

	assign en_out   = !out_valid || !out_stall;
	assign en_3     = !v_s3 || en_out;
	assign en_2     = !v_s2 || en_3;
	assign en_1     = !v_s1 || en_2;
	assign in_stall = !en_1;
	assign accept   = in_valid && en_1;
	assign leave_s1 = v_s1 && en_2;

	always_comb begin
		w_req = 32'(cfg_data[IMGW_W-1:0]);
		if (w_req > 32'(MAX_WIDTH)) begin
			w_sel = 32'(MAX_WIDTH);
		end else if (w_req == 32'd0) begin
			w_sel = 32'd1;
		end else begin
			w_sel = w_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmax_q <= WMAX_RST;
			hmax_q <= HMAX_RST;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					wmax_q <= AW'(w_sel - 32'd1);
					col_q  <= '0;
					row_q  <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					hmax_q <= (cfg_data == '0) ? '0 : cfg_data - 1'b1;
					col_q  <= '0;
					row_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == wmax_q) begin
				col_q <= '0;
				row_q <= (row_q == hmax_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	rgbb_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up_rd),
		.wr_en   (leave_s1),
		.wr_addr (col_s1),
		.wr_data (mid_rd)
	);

	rgbb_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_middle (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (mid_rd),
		.wr_en   (leave_s1),
		.wr_addr (col_s1),
		.wr_data (pix_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_1) begin
				v_s1 <= in_valid;
			end
			if (en_2) begin
				v_s2 <= v_s1 && emit_s1;
			end
			if (en_3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= '{r: red_in, g: green_in, b: blue_in};
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	assign emit_s1 = (row_s1 >= ROW_W'(2)) && (col_s1 >= AW'(2));
	assign last_s1 = (row_s1 == hmax_q) && (col_s1 == wmax_q);

	always_comb begin
		newcol[0] = up_rd;
		newcol[1] = mid_rd;
		newcol[2] = pix_s1;
		for (int k = 0; k < 3; k++) begin
			taps_r[k]     = win0_q[k].r;
			taps_g[k]     = win0_q[k].g;
			taps_b[k]     = win0_q[k].b;
			taps_r[k + 3] = win1_q[k].r;
			taps_g[k + 3] = win1_q[k].g;
			taps_b[k + 3] = win1_q[k].b;
			taps_r[k + 6] = newcol[k].r;
			taps_g[k + 6] = newcol[k].g;
			taps_b[k + 6] = newcol[k].b;
		end
	end

	// every pixel shifts the window, emitting or not
	always_ff @(posedge clk) begin
		if (leave_s1) begin
			for (int k = 0; k < 3; k++) begin
				win0_q[k] <= win1_q[k];
				win1_q[k] <= newcol[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_2) begin
			orow_s2 <= row_s1 - 1'b1;
			ocol_s2 <= COL_W'(col_s1 - 1'b1);
			last_s2 <= last_s1;
		end
		if (en_3) begin
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			last_s3 <= last_s2;
		end
	end

	rgbb_lane u_lane_r (
		.clk     (clk),
		.en_s2   (en_2),
		.en_s3   (en_3),
		.taps    (taps_r),
		.mean_s3 (mean_r_s3)
	);

	rgbb_lane u_lane_g (
		.clk     (clk),
		.en_s2   (en_2),
		.en_s3   (en_3),
		.taps    (taps_g),
		.mean_s3 (mean_g_s3)
	);

	rgbb_lane u_lane_b (
		.clk     (clk),
		.en_s2   (en_2),
		.en_s3   (en_3),
		.taps    (taps_b),
		.mean_s3 (mean_b_s3)
	);

	// merge the three channels with position into the output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			red_out     <= mean_r_s3;
			green_out   <= mean_g_s3;
			blue_out    <= mean_b_s3;
			out_row     <= orow_s3;
			out_col     <= ocol_s3;
			last_result <= last_s3;
		end
	end

endmodule
